>>> rtl/itf_pkg.sv
package itf_pkg;
  localparam int unsigned MagW  = 64;
  localparam int unsigned CharW = 8;
  localparam int unsigned RegW  = 8;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CntW  = 7;

  // register indexes
  localparam logic [IdxW-1:0] RegBase   = 3'd0;
  localparam logic [IdxW-1:0] RegUpper  = 3'd1;
  localparam logic [IdxW-1:0] RegOmit   = 3'd2;
  localparam logic [IdxW-1:0] RegSign   = 3'd3;
  localparam logic [IdxW-1:0] RegLeft   = 3'd4;
  localparam logic [IdxW-1:0] RegMinDig = 3'd5;
  localparam logic [IdxW-1:0] RegWidth  = 3'd6;
  localparam logic [IdxW-1:0] RegFill   = 3'd7;

  localparam logic [1:0] BaseDec = 2'd0;
  localparam logic [1:0] BaseHex = 2'd1;
  localparam logic [1:0] BaseOct = 2'd2;
  localparam logic [1:0] BaseBin = 2'd3;

  localparam logic [1:0] SignNone  = 2'd0;
  localparam logic [1:0] SignPlus  = 2'd1;
  localparam logic [1:0] SignBlank = 2'd2;

  typedef struct packed {
    logic [1:0]      base;
    logic            upper;
    logic            omit;
    logic [1:0]      sign;
    logic            left;
    logic [CntW-1:0] min_dig;
    logic [CntW-1:0] width;
    logic [7:0]      fill;
  } cfg_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic up);
    if (d < 4'd10) return 8'h30 + {4'h0, d};
    return (up ? 8'h37 : 8'h57) + {4'h0, d};
  endfunction
endpackage

>>> rtl/itf_if.sv
interface itf_in_if;
  logic                    valid;
  logic                    ready;
  logic [itf_pkg::MagW-1:0] magnitude;
  logic                    is_negative;
  modport source (output valid, magnitude, is_negative, input ready);
  modport sink   (input valid, magnitude, is_negative, output ready);
endinterface

interface itf_out_if;
  logic                     valid;
  logic                     ready;
  logic [itf_pkg::CharW-1:0] character;
  logic                     last;
  logic                     truncated;
  modport source (output valid, character, last, truncated, input ready);
  modport sink   (input valid, character, last, truncated, output ready);
endinterface

>>> rtl/itf_digit_conv.sv
// Bit-serial digit conversion. Decimal: double-dabble into 20 BCD
// digits. Other bases: value loaded as is into the digit shift register.
// Then leading zero digits are shifted out one per cycle (at least one digit kept).
// The most significant digit sits at the top; the emitter shifts one digit out per
// digit character.
module itf_digit_conv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [itf_pkg::MagW-1:0] mag_i,
  input  logic [1:0]               base_i,
  input  logic                     shift_i,
  output logic                     done_o,
  output logic [3:0]               dig_o,
  output logic [itf_pkg::CntW-1:0] nd_o
);
  import itf_pkg::*;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhDabble = 2'd1;
  localparam logic [1:0] PhNorm   = 2'd2;

  // digit positions held for each base
  localparam logic [CntW-1:0] NdDec = 7'd20;
  localparam logic [CntW-1:0] NdHex = 7'd16;
  localparam logic [CntW-1:0] NdOct = 7'd22;
  localparam logic [CntW-1:0] NdBin = 7'd64;

  logic [1:0]      ph_q, ph_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0] sh_q, sh_d;
  logic [79:0]     val_q, val_d;
  logic [79:0]     adj;
  logic [79:0]     val_sh;
  logic [3:0]      dig_top;
  logic            done_q, done_d;

  // add-3 correction on every BCD digit
  always_comb begin
    for (int k = 0; k < 20; k++) begin
      adj[k*4 +: 4] = (val_q[k*4 +: 4] > 4'd4) ? val_q[k*4 +: 4] + 4'd3 : val_q[k*4 +: 4];
    end
  end

  // top digit and one-digit shift for the selected base
  always_comb begin
    unique case (base_i)
      BaseOct: begin
        dig_top = {1'b0, val_q[79:77]};
        val_sh  = {val_q[76:0], 3'b000};
      end
      BaseBin: begin
        dig_top = {3'b000, val_q[79]};
        val_sh  = {val_q[78:0], 1'b0};
      end
      BaseDec, BaseHex: begin
        dig_top = val_q[79:76];
        val_sh  = {val_q[75:0], 4'h0};
      end
    endcase
  end

  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; sh_d = sh_q; val_d = val_q; done_d = 1'b0;
    if (start_i) begin
      unique case (base_i)
        BaseDec: begin
          val_d = '0; sh_d = mag_i; cnt_d = '0; ph_d = PhDabble;
        end
        BaseHex: begin
          val_d = {mag_i, 16'h0}; cnt_d = NdHex; ph_d = PhNorm;
        end
        BaseOct: begin
          val_d = {2'b00, mag_i, 14'h0}; cnt_d = NdOct; ph_d = PhNorm;
        end
        BaseBin: begin
          val_d = {mag_i, 16'h0}; cnt_d = NdBin; ph_d = PhNorm;
        end
      endcase
    end else begin
      unique case (ph_q)
        PhDabble: begin
          // one value bit per cycle into the BCD register
          val_d = {adj[78:0], sh_q[MagW-1]};
          sh_d  = {sh_q[MagW-2:0], 1'b0};
          if (cnt_q == 7'd63) begin
            ph_d = PhNorm; cnt_d = NdDec;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
        PhNorm: begin
          // drop one leading zero digit per cycle
          if (dig_top == 4'd0 && cnt_q > 7'd1) begin
            val_d = val_sh; cnt_d = cnt_q - 7'd1;
          end else begin
            ph_d = PhIdle; done_d = 1'b1;
          end
        end
        default: begin
          if (shift_i) val_d = val_sh;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; cnt_q <= '0; done_q <= 1'b0; sh_q <= '0; val_q <= '0;
    end else begin
      ph_q <= ph_d; cnt_q <= cnt_d; done_q <= done_d; sh_q <= sh_d; val_q <= val_d;
    end
  end

  assign done_o = done_q;
  assign dig_o  = dig_top;
  assign nd_o   = cnt_q;
endmodule

>>> rtl/itf_emitter.sv
// Character sequencer: walks fill, sign, prefix, zeros, digits, fill, one per transaction.
module itf_emitter #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  itf_pkg::cfg_t            cfg_i,
  input  logic                     neg_i,
  input  logic [3:0]               dig_i,
  input  logic [itf_pkg::CntW-1:0] nd_i,
  output logic                     shift_o,
  output logic                     busy_o,
  itf_out_if.source                out
);
  import itf_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SSetup = 4'd1;
  localparam logic [3:0] SFillL = 4'd2;
  localparam logic [3:0] SSign  = 4'd3;
  localparam logic [3:0] SPre0  = 4'd4;
  localparam logic [3:0] SPreL  = 4'd5;
  localparam logic [3:0] SZero  = 4'd6;
  localparam logic [3:0] SDig   = 4'd7;
  localparam logic [3:0] SFillR = 4'd8;
  localparam logic [7:0] CapLen = 8'(MAX_CHARS);

  logic [3:0]      seg_q, seg_d;
  logic [7:0]      cnt_q, cnt_d, rem_q, rem_d;
  logic [7:0]      nbody_q, nbody_d, nfill_q, nfill_d;
  logic [CntW-1:0] nzero_q, nzero_d;
  logic            nsign_q, nsign_d, npre_q, npre_d, trunc_q, trunc_d;
  logic            nsign_c, npre_c;
  logic [CntW-1:0] nmax;
  logic [7:0]      ntext, fill_len, seg_len;
  logic [3:0]      after_pre, after_sign, after_fill, tgt;
  logic            chr_act, fire;
  logic [7:0]      ch, fillc;

  // text section sizes
  always_comb begin
    nsign_c = neg_i || cfg_i.sign == SignPlus || cfg_i.sign == SignBlank;
    npre_c  = (cfg_i.base != BaseDec) && !cfg_i.omit;
    nmax    = (cfg_i.min_dig > nd_i) ? cfg_i.min_dig : nd_i;
    ntext   = ({1'b0, cfg_i.width} > nbody_q) ? {1'b0, cfg_i.width} : nbody_q;
  end

  // next non-empty section and its length
  always_comb begin
    after_pre  = (nzero_q != '0) ? SZero : SDig;
    after_sign = npre_q ? SPre0 : after_pre;
    after_fill = nsign_q ? SSign : after_sign;
    fill_len   = (seg_q == SSetup) ? ntext - nbody_q : nfill_q;
    unique case (seg_q)
      SSetup:  tgt = (!cfg_i.left && fill_len != 8'd0) ? SFillL : after_fill;
      SFillL:  tgt = after_fill;
      SSign:   tgt = after_sign;
      SPre0:   tgt = SPreL;
      SPreL:   tgt = after_pre;
      SZero:   tgt = SDig;
      SDig:    tgt = SFillR;
      default: tgt = SIdle;
    endcase
    unique case (tgt)
      SFillL, SFillR: seg_len = fill_len;
      SZero:          seg_len = {1'b0, nzero_q};
      SDig:           seg_len = {1'b0, nd_i};
      default:        seg_len = 8'd1;
    endcase
  end

  assign chr_act = (seg_q != SIdle) && (seg_q != SSetup);
  assign fire    = chr_act && out.ready;

  always_comb begin
    seg_d = seg_q; cnt_d = cnt_q; rem_d = rem_q; nbody_d = nbody_q; nfill_d = nfill_q;
    nzero_d = nzero_q; nsign_d = nsign_q; npre_d = npre_q; trunc_d = trunc_q;
    unique case (seg_q)
      SIdle: begin
        if (start_i) begin
          nbody_d = {1'b0, nmax} + {7'd0, nsign_c} + (npre_c ? 8'd2 : 8'd0);
          nzero_d = nmax - nd_i;
          nsign_d = nsign_c;
          npre_d  = npre_c;
          seg_d   = SSetup;
        end
      end
      SSetup: begin
        nfill_d = fill_len;
        trunc_d = ntext > CapLen;
        rem_d   = (ntext > CapLen) ? CapLen : ntext;
        seg_d   = tgt;
        cnt_d   = seg_len;
      end
      default: begin
        if (fire) begin
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            seg_d = SIdle;
          end else if (cnt_q == 8'd1) begin
            seg_d = tgt; cnt_d = seg_len;
          end else begin
            cnt_d = cnt_q - 8'd1;
          end
        end
      end
    endcase
  end

  // character of the current section
  always_comb begin
    fillc = (cfg_i.fill == 8'd0) ? 8'h20 : cfg_i.fill;
    unique case (seg_q)
      SFillL, SFillR: ch = fillc;
      SSign:          ch = neg_i ? 8'h2d : ((cfg_i.sign == SignPlus) ? 8'h2b : 8'h20);
      SPre0, SZero:   ch = 8'h30;
      SPreL: begin
        unique case (cfg_i.base)
          BaseHex: ch = cfg_i.upper ? 8'h58 : 8'h78;
          BaseOct: ch = cfg_i.upper ? 8'h4f : 8'h6f;
          default: ch = cfg_i.upper ? 8'h42 : 8'h62;
        endcase
      end
      SDig:           ch = digit_char(dig_i, cfg_i.upper);
      default:        ch = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SIdle; cnt_q <= '0; rem_q <= '0; nbody_q <= '0; nfill_q <= '0;
      nzero_q <= '0; nsign_q <= 1'b0; npre_q <= 1'b0; trunc_q <= 1'b0;
    end else begin
      seg_q <= seg_d; cnt_q <= cnt_d; rem_q <= rem_d; nbody_q <= nbody_d; nfill_q <= nfill_d;
      nzero_q <= nzero_d; nsign_q <= nsign_d; npre_q <= npre_d; trunc_q <= trunc_d;
    end
  end

  assign shift_o       = fire && (seg_q == SDig);
  assign busy_o        = (seg_q != SIdle);
  assign out.valid     = chr_act;
  assign out.character = ch;
  assign out.last      = (rem_q == 8'd1);
  assign out.truncated = (rem_q == 8'd1) && trunc_q;
endmodule

>>> rtl/integer_to_text_formatter_unit.sv
// Channel  | Dir | Payload
// in_if    | in  | magnitude[63:0], is_negative
// out_if   | out | character[7:0], last, truncated
// cfg      | in  | cfg_we_i, cfg_idx_i[2:0], cfg_data_i[7:0]
// One item: decimal runs double-dabble first; every base then drops one leading
// zero digit per cycle (up to 19 dec, 15 hex, 21 oct, 63 bin), then done hand-over
// and set-up, then one character per unstalled cycle, 1 to MAX_CHARS characters.
// Next item accepted the cycle after the last character. Output stalls hold the
// sequencer. Reset restores register defaults.
module integer_to_text_formatter_unit #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [itf_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [itf_pkg::RegW-1:0]   cfg_data_i,
  itf_in_if.sink                     in_if,
  itf_out_if.source                  out_if
);
  import itf_pkg::*;

  cfg_t         cfg_q;
  logic         busy_q, neg_q;
  logic         conv_done, emit_busy, dig_shift, acc;
  logic [3:0]   dig;
  logic [CntW-1:0] nd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base: 2'd0, upper: 1'b0, omit: 1'b0, sign: 2'd0, left: 1'b0,
                 min_dig: 7'd0, width: 7'd0, fill: 8'd32};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBase:   cfg_q.base    <= cfg_data_i[1:0];
        RegUpper:  cfg_q.upper   <= cfg_data_i[0];
        RegOmit:   cfg_q.omit    <= cfg_data_i[0];
        RegSign:   cfg_q.sign    <= cfg_data_i[1:0];
        RegLeft:   cfg_q.left    <= cfg_data_i[0];
        RegMinDig: cfg_q.min_dig <= cfg_data_i[6:0];
        RegWidth:  cfg_q.width   <= cfg_data_i[6:0];
        default:   cfg_q.fill    <= cfg_data_i;
      endcase
    end
  end

  assign in_if.ready = !busy_q;
  assign acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (acc) busy_q <= 1'b1;
    else if (emit_busy && out_if.valid && out_if.ready && out_if.last) busy_q <= 1'b0;
  end

  always_ff @(posedge clk_i) if (acc) neg_q <= in_if.is_negative;

  itf_digit_conv u_conv (
    .clk_i, .rst_ni, .start_i(acc), .mag_i(in_if.magnitude), .base_i(cfg_q.base),
    .shift_i(dig_shift), .done_o(conv_done), .dig_o(dig), .nd_o(nd)
  );

  itf_emitter #(.MAX_CHARS(MAX_CHARS)) u_emit (
    .clk_i, .rst_ni, .start_i(conv_done), .cfg_i(cfg_q), .neg_i(neg_q),
    .dig_i(dig), .nd_i(nd), .shift_o(dig_shift), .busy_o(emit_busy), .out(out_if)
  );

  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> busy_q) else $error("output while idle");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.truncated |-> out_if.last) else $error("truncated off last");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_busy |-> !in_if.ready) else $error("accept during emit");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.character)))
    else $error("stalled character moved");
endmodule
